[rtl/core/gbi_pkg.sv]
// gbi_pkg: types, state codes and saturation helpers for the gravity body integrator
// no dependencies; imported by every module under rtl/core
`default_nettype none

package gbi_pkg;

    localparam int FRAC_BITS = 32;

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [62:0] ONE_Q   = 63'(64'd1 << FRAC_BITS);

    localparam logic [3:0] ADDR_OWN_MASS = 4'h0;
    localparam logic [3:0] ADDR_G_SCALE  = 4'h8;

    typedef enum logic [1:0] {
        REQ_INTERACT = 2'd0,
        REQ_ADVANCE  = 2'd1,
        REQ_LOAD     = 2'd2,
        REQ_NONE     = 2'd3
    } req_code_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ_MUL,
        ST_SQ_WAIT,
        ST_CHECK,
        ST_SQRT_WAIT,
        ST_GM_MUL,
        ST_GM_WAIT,
        ST_F_DIV,
        ST_F_WAIT,
        ST_A_MUL,
        ST_A_MUL_WAIT,
        ST_A_DIV,
        ST_A_DIV_WAIT,
        ST_AT_MUL,
        ST_AT_WAIT,
        ST_VT_MUL,
        ST_VT_WAIT,
        ST_H_MUL,
        ST_H_WAIT,
        ST_DONE
    } st_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [63:0] in_x;
        logic signed [63:0] in_y;
        logic signed [63:0] in_z;
        logic signed [63:0] in_vx;
        logic signed [63:0] in_vy;
        logic signed [63:0] in_vz;
        logic [62:0]        other_mass;
        logic [62:0]        timestep;
    } req_t;

    typedef struct packed {
        logic               status;
        logic signed [63:0] out_x;
        logic signed [63:0] out_y;
        logic signed [63:0] out_z;
        logic signed [63:0] out_vx;
        logic signed [63:0] out_vy;
        logic signed [63:0] out_vz;
        logic signed [63:0] acc_x;
        logic signed [63:0] acc_y;
        logic signed [63:0] acc_z;
    } rsp_t;

    // operands handed to a multi-cycle unit
    typedef struct packed {
        logic         start;
        logic [127:0] op_a;
        logic [127:0] op_b;
    } unit_req_t;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        mag64 = v[63] ? (64'd0 - v) : v;
    endfunction

    // sign plus magnitude to saturated signed 64 bits
    function automatic logic [63:0] satmag(input logic [127:0] m, input logic neg);
        if (neg) begin
            satmag = (m > {64'd0, S64_MIN}) ? S64_MIN : (64'd0 - m[63:0]);
        end else begin
            satmag = (m > {64'd0, S64_MAX}) ? S64_MAX : m[63:0];
        end
    endfunction

    function automatic logic [63:0] sat66(input logic [65:0] x);
        if ((x[65:63] == 3'b000) || (x[65:63] == 3'b111)) begin
            sat66 = x[63:0];
        end else begin
            sat66 = x[65] ? S64_MIN : S64_MAX;
        end
    endfunction

    function automatic logic [65:0] sx66(input logic [63:0] v);
        sx66 = {{2{v[63]}}, v};
    endfunction

endpackage

`default_nettype wire

[rtl/core/gbi_mul.sv]
// gbi_mul: 64x64 unsigned multiplier built from one 32x32 multiplier, four partial products summed in turn
// depends on gbi_pkg
`default_nettype none

module gbi_mul
    import gbi_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire unit_req_t    req,
    output logic              done,
    output logic [127:0]      prod
);

    logic [63:0]  a_reg, b_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   sh_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [127:0] acc_reg;
    logic [31:0]  a_half, b_half;
    logic [127:0] pp_shifted;

    assign a_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];

    always_comb begin
        unique case (sh_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd1:    pp_shifted = {32'd0, pp_reg, 32'd0};
            default: pp_shifted = {pp_reg, 64'd0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg   <= req.op_a[63:0];
            b_reg   <= req.op_b[63:0];
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (cnt_reg != 3'd4) begin
                pp_reg <= {32'd0, a_half} * {32'd0, b_half};
                sh_reg <= 2'({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]});
            end
            if (cnt_reg != 3'd0) begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

[rtl/core/gbi_div.sv]
// gbi_div: 128-bit unsigned restoring divider, one quotient bit per cycle
// depends on gbi_pkg
`default_nettype none

module gbi_div
    import gbi_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire unit_req_t    req,
    output logic              done,
    output logic [127:0]      quo
);

    logic [127:0] num_reg, den_reg, quo_reg;
    logic [127:0] rem_reg;
    logic [6:0]   cnt_reg;
    logic         busy_reg, done_reg;
    logic [128:0] rem_sh, rem_sub;
    logic         take;

    assign rem_sh  = {rem_reg, num_reg[127]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign take    = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd127) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.op_a;
            den_reg <= req.op_b;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[126:0], 1'b0};
            rem_reg <= take ? rem_sub[127:0] : rem_sh[127:0];
            quo_reg <= {quo_reg[126:0], take};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

[rtl/core/gbi_sqrt.sv]
// gbi_sqrt: integer square root of a 128-bit value, one root bit per cycle
// depends on gbi_pkg
`default_nettype none

module gbi_sqrt
    import gbi_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire unit_req_t    req,
    output logic              done,
    output logic [63:0]       root
);

    logic [127:0] src_reg;
    logic [63:0]  root_reg;
    logic [64:0]  rem_reg;
    logic [5:0]   cnt_reg;
    logic         busy_reg, done_reg;
    logic [66:0]  rem_sh, trial, rem_sub;
    logic         take;

    assign rem_sh  = {rem_reg, src_reg[127:126]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign rem_sub = rem_sh - trial;
    assign take    = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder never exceeds twice the root, so 65 bits hold it
    always_ff @(posedge aclk) begin
        if (req.start) begin
            src_reg  <= req.op_a;
            root_reg <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            src_reg  <= {src_reg[125:0], 2'b00};
            rem_reg  <= take ? rem_sub[64:0] : rem_sh[64:0];
            root_reg <= {root_reg[62:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

[rtl/core/gravity_body_integrator.sv]
// gravity_body_integrator: one body of a direct-sum gravity simulation, Q32.32
// depends on gbi_pkg, gbi_mul, gbi_div, gbi_sqrt
//
//   port group      direction  what moves
//   s_*             in         one request beat (interact, advance, load)
//   m_*             out        one result beat per request
//   p* (APB)        in/out     own_mass at 0x0, g_scale at 0x8
//
// interact: four divisions, a square root and seven multiplies between accept and
//   result; coincident bodies go from the check straight to the result
// advance: nine multiplies; load and unknown requests go straight to the result
// s_ready is high only in idle; a result waits in the output register and a new
//   request may be taken meanwhile
// synchronous active-low reset clears position, velocity and accumulator
`default_nettype none

module gravity_body_integrator
    import gbi_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire req_t         s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output rsp_t              m_data,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    st_t state_reg, state_next;

    logic [62:0] own_mass_reg, g_scale_reg;

    logic signed [63:0] pos_reg [3];
    logic signed [63:0] vel_reg [3];
    logic signed [63:0] acc_reg [3];
    logic signed [63:0] accsh_reg [3];
    logic signed [63:0] d_reg [3];

    req_t         req_reg;
    logic [1:0]   idx_reg;
    logic [127:0] s_reg;
    logic [63:0]  r_reg, f_reg;
    logic [63:0]  at_reg, vt_reg;
    logic         status_reg;
    logic         m_valid_reg;
    rsp_t         m_data_reg;

    unit_req_t    mul_req, div_req, sqrt_req;
    logic         mul_done, div_done, sqrt_done;
    logic [127:0] mul_prod, div_quo;
    logic [63:0]  sqrt_root;

    logic         accept;
    logic         out_free;
    logic [127:0] gm, prod_f, prod_h;
    logic [63:0]  p_val;
    logic [63:0]  h_val, a_val;
    logic [64:0]  diff [3];

    gbi_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mul_req),
                   .done(mul_done), .prod(mul_prod));
    gbi_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req),
                   .done(div_done), .quo(div_quo));
    gbi_sqrt u_sqrt (.aclk(aclk), .aresetn(aresetn), .req(sqrt_req),
                     .done(sqrt_done), .root(sqrt_root));

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // configuration port
    assign pready = 1'b1;
    assign prdata = paddr[3] ? {1'b0, g_scale_reg} : {1'b0, own_mass_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_mass_reg <= ONE_Q;
            g_scale_reg  <= ONE_Q;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[3]) begin
                g_scale_reg <= pwdata[62:0];
            end else begin
                own_mass_reg <= pwdata[62:0];
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_data.req_type)
                        REQ_INTERACT: state_next = ST_DIFF;
                        REQ_ADVANCE:  state_next = ST_AT_MUL;
                        default:      state_next = ST_DONE;
                    endcase
                end
            end
            ST_DIFF:       state_next = ST_SQ_MUL;
            ST_SQ_MUL:     state_next = ST_SQ_WAIT;
            ST_SQ_WAIT: begin
                if (mul_done) state_next = (idx_reg == 2'd2) ? ST_CHECK : ST_SQ_MUL;
            end
            ST_CHECK:      state_next = (s_reg == '0) ? ST_DONE : ST_SQRT_WAIT;
            ST_SQRT_WAIT: begin
                if (sqrt_done) state_next = ST_GM_MUL;
            end
            ST_GM_MUL:     state_next = ST_GM_WAIT;
            ST_GM_WAIT: begin
                if (mul_done) state_next = ST_F_DIV;
            end
            ST_F_DIV:      state_next = ST_F_WAIT;
            ST_F_WAIT: begin
                if (div_done) state_next = ST_A_MUL;
            end
            ST_A_MUL:      state_next = ST_A_MUL_WAIT;
            ST_A_MUL_WAIT: begin
                if (mul_done) state_next = ST_A_DIV;
            end
            ST_A_DIV:      state_next = ST_A_DIV_WAIT;
            ST_A_DIV_WAIT: begin
                if (div_done) state_next = (idx_reg == 2'd2) ? ST_DONE : ST_A_MUL;
            end
            ST_AT_MUL:     state_next = ST_AT_WAIT;
            ST_AT_WAIT: begin
                if (mul_done) state_next = ST_VT_MUL;
            end
            ST_VT_MUL:     state_next = ST_VT_WAIT;
            ST_VT_WAIT: begin
                if (mul_done) state_next = ST_H_MUL;
            end
            ST_H_MUL:      state_next = ST_H_WAIT;
            ST_H_WAIT: begin
                if (mul_done) state_next = (idx_reg == 2'd2) ? ST_DONE : ST_AT_MUL;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // unit starts and operands
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        mul_req  = '0;
        div_req  = '0;
        sqrt_req = '0;
        unique case (state_reg)
            ST_SQ_MUL: begin
                mul_req.start = 1'b1;
                mul_req.op_a  = {64'd0, mag64(d_reg[idx_reg])};
                mul_req.op_b  = {64'd0, mag64(d_reg[idx_reg])};
            end
            ST_CHECK: begin
                sqrt_req.start = (s_reg != '0);
                sqrt_req.op_a  = s_reg;
            end
            ST_GM_MUL: begin
                mul_req.start = 1'b1;
                mul_req.op_a  = {65'd0, g_scale_reg};
                mul_req.op_b  = {65'd0, req_reg.other_mass};
            end
            ST_F_DIV: begin
                div_req.start = 1'b1;
                div_req.op_a  = {64'd0, p_val} << FRAC_BITS;
                div_req.op_b  = s_reg;
            end
            ST_A_MUL: begin
                mul_req.start = 1'b1;
                mul_req.op_a  = {64'd0, f_reg};
                mul_req.op_b  = {64'd0, mag64(d_reg[idx_reg])};
            end
            ST_A_DIV: begin
                div_req.start = 1'b1;
                div_req.op_a  = mul_prod;
                div_req.op_b  = {64'd0, r_reg};
            end
            ST_AT_MUL: begin
                mul_req.start = 1'b1;
                mul_req.op_a  = {64'd0, mag64(acc_reg[idx_reg])};
                mul_req.op_b  = {65'd0, req_reg.timestep};
            end
            ST_VT_MUL: begin
                mul_req.start = 1'b1;
                mul_req.op_a  = {64'd0, mag64(vel_reg[idx_reg])};
                mul_req.op_b  = {65'd0, req_reg.timestep};
            end
            ST_H_MUL: begin
                mul_req.start = 1'b1;
                mul_req.op_a  = {64'd0, mag64(at_reg)};
                mul_req.op_b  = {65'd0, req_reg.timestep};
            end
            default: begin
                mul_req  = '0;
            end
        endcase
    end

    // datapath helpers
    always_comb begin
        diff[0] = {req_reg.in_x[63], req_reg.in_x} - {pos_reg[0][63], pos_reg[0]};
        diff[1] = {req_reg.in_y[63], req_reg.in_y} - {pos_reg[1][63], pos_reg[1]};
        diff[2] = {req_reg.in_z[63], req_reg.in_z} - {pos_reg[2][63], pos_reg[2]};
    end

    // saturated (G*M) >> F, reused as p in the next division
    assign gm     = mul_prod >> FRAC_BITS;
    assign p_val  = (gm[127:64] != '0) ? U64_MAX : gm[63:0];
    assign prod_f = mul_prod >> FRAC_BITS;
    assign prod_h = mul_prod >> (FRAC_BITS + 1);
    assign h_val  = satmag(prod_h, at_reg[63]);
    assign a_val  = satmag(div_quo, d_reg[idx_reg][63]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_data.req_type == REQ_LOAD)) begin
                        pos_reg[0] <= s_data.in_x;
                        pos_reg[1] <= s_data.in_y;
                        pos_reg[2] <= s_data.in_z;
                        vel_reg[0] <= s_data.in_vx;
                        vel_reg[1] <= s_data.in_vy;
                        vel_reg[2] <= s_data.in_vz;
                        for (int i = 0; i < 3; i++) begin
                            acc_reg[i] <= '0;
                        end
                    end
                end
                ST_A_DIV_WAIT: begin
                    if (div_done) begin
                        acc_reg[idx_reg] <= sat66(sx66(acc_reg[idx_reg]) + sx66(a_val));
                    end
                end
                ST_H_WAIT: begin
                    if (mul_done) begin
                        pos_reg[idx_reg]   <= sat66(sx66(pos_reg[idx_reg]) + sx66(vt_reg)
                                                    + sx66(h_val));
                        vel_reg[idx_reg]   <= sat66(sx66(vel_reg[idx_reg]) + sx66(at_reg));
                        acc_reg[idx_reg]   <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_reg    <= s_data;
                    idx_reg    <= '0;
                    status_reg <= 1'b0;
                    s_reg      <= '0;
                end
            end
            ST_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    d_reg[i] <= sat66({diff[i][64], diff[i]});
                end
            end
            ST_SQ_WAIT: begin
                if (mul_done) begin
                    s_reg   <= s_reg + mul_prod;
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            ST_CHECK: begin
                status_reg <= (s_reg == '0);
            end
            ST_SQRT_WAIT: begin
                if (sqrt_done) r_reg <= sqrt_root;
            end
            ST_GM_WAIT: begin
                idx_reg <= '0;
            end
            ST_F_WAIT: begin
                if (div_done) f_reg <= (div_quo[127:64] != '0) ? U64_MAX : div_quo[63:0];
            end
            ST_A_DIV_WAIT: begin
                if (div_done) idx_reg <= idx_reg + 2'd1;
            end
            ST_AT_WAIT: begin
                if (mul_done) at_reg <= satmag(prod_f, acc_reg[idx_reg][63]);
            end
            ST_VT_WAIT: begin
                if (mul_done) vt_reg <= satmag(prod_f, vel_reg[idx_reg][63]);
            end
            ST_H_WAIT: begin
                if (mul_done) begin
                    accsh_reg[idx_reg] <= acc_reg[idx_reg];
                    idx_reg            <= idx_reg + 2'd1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_data_reg.status <= status_reg;
                    if (req_reg.req_type == REQ_INTERACT) begin
                        m_data_reg.out_x <= d_reg[0];
                        m_data_reg.out_y <= d_reg[1];
                        m_data_reg.out_z <= d_reg[2];
                    end else begin
                        m_data_reg.out_x <= pos_reg[0];
                        m_data_reg.out_y <= pos_reg[1];
                        m_data_reg.out_z <= pos_reg[2];
                    end
                    m_data_reg.out_vx <= vel_reg[0];
                    m_data_reg.out_vy <= vel_reg[1];
                    m_data_reg.out_vz <= vel_reg[2];
                    if (req_reg.req_type == REQ_ADVANCE) begin
                        m_data_reg.acc_x <= accsh_reg[0];
                        m_data_reg.acc_y <= accsh_reg[1];
                        m_data_reg.acc_z <= accsh_reg[2];
                    end else begin
                        m_data_reg.acc_x <= acc_reg[0];
                        m_data_reg.acc_y <= acc_reg[1];
                        m_data_reg.acc_z <= acc_reg[2];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_coincident_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status) |->
            (m_data.out_x == '0 && m_data.out_y == '0 && m_data.out_z == '0))
        else $error("coincident result carries a nonzero difference");

    a_mul_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_SQ_WAIT || state_reg == ST_GM_WAIT ||
                      state_reg == ST_A_MUL_WAIT || state_reg == ST_AT_WAIT ||
                      state_reg == ST_VT_WAIT || state_reg == ST_H_WAIT))
        else $error("multiplier finished outside a wait state");

    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_F_WAIT || state_reg == ST_A_DIV_WAIT))
        else $error("divider finished outside a wait state");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_DONE)
        else $error("result beat raised outside the done state");
`endif

endmodule

`default_nettype wire

[bench/tb_gravity_body_integrator.sv]
// testbench for gravity_body_integrator: directed table then random requests, checked
// against an in-bench body-state predictor or typed rows; depends on gbi_pkg and the rtl
`timescale 1ns / 1ps

module tb_gravity_body_integrator;
    import gbi_pkg::*;

    localparam int N_RANDOM = 1350;
    localparam longint CYCLE_LIMIT = 64'd6_000_000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_data;
    logic m_valid;
    logic m_ready;
    rsp_t m_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic pready;

    gravity_body_integrator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor copy of the body
    logic [62:0] mdl_g;
    logic [63:0] mdl_pos [3];
    logic [63:0] mdl_vel [3];
    logic [63:0] mdl_acc [3];

    rsp_t expected_q [$];
    int errors = 0;
    longint cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [63:0] sat128(input logic signed [127:0] x);
        if (x > $signed({64'd0, S64_MAX})) return S64_MAX;
        if (x < -$signed({64'd0, S64_MAX}) - 1) return S64_MIN;
        return x[63:0];
    endfunction

    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    function automatic logic [63:0] signed_sat(input logic [127:0] m, input logic neg);
        if (neg) return (m > {64'd0, S64_MIN}) ? S64_MIN : 64'd0 - m[63:0];
        return (m > {64'd0, S64_MAX}) ? S64_MAX : m[63:0];
    endfunction

    function automatic logic [63:0] scale_mul(input logic [63:0] v, input logic [63:0] t,
                                              input int sh);
        logic [127:0] p;
        p = abs64(v) * {64'd0, t};
        p = p >> sh;
        return signed_sat(p, v[63]);
    endfunction

    function automatic logic [63:0] isqrt(input logic [127:0] s);
        logic [63:0] r, c;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= s) r = c;
        end
        return r;
    endfunction

    function automatic logic signed [127:0] sx(input logic [63:0] v);
        return {{64{v[63]}}, v};
    endfunction

    // works out the result of one request and moves the body state
    function automatic rsp_t body_step(input req_t r);
        rsp_t o;
        logic [63:0] d [3];
        logic [127:0] s, gm, fq, q;
        logic [63:0] rt, p, f, a, at, vt, h;
        o = '0;
        for (int i = 0; i < 3; i++) d[i] = mdl_pos[i];
        case (req_code_t'(r.req_type))
            REQ_INTERACT: begin
                s = 0;
                d[0] = sat128(sx(r.in_x) - sx(mdl_pos[0]));
                d[1] = sat128(sx(r.in_y) - sx(mdl_pos[1]));
                d[2] = sat128(sx(r.in_z) - sx(mdl_pos[2]));
                for (int i = 0; i < 3; i++)
                    s = s + {64'd0, abs64(d[i])} * {64'd0, abs64(d[i])};
                if (s == 0) begin
                    o.status = 1'b1;
                end else begin
                    rt = isqrt(s);
                    gm = ({65'd0, mdl_g} * {65'd0, r.other_mass}) >> FRAC_BITS;
                    p = (gm[127:64] != 0) ? U64_MAX : gm[63:0];
                    fq = ({64'd0, p} << FRAC_BITS) / s;
                    f = (fq[127:64] != 0) ? U64_MAX : fq[63:0];
                    for (int i = 0; i < 3; i++) begin
                        q = ({64'd0, f} * {64'd0, abs64(d[i])}) / {64'd0, rt};
                        a = signed_sat(q, d[i][63]);
                        mdl_acc[i] = sat128(sx(mdl_acc[i]) + sx(a));
                    end
                end
            end
            REQ_ADVANCE: begin
                for (int i = 0; i < 3; i++) begin
                    at = scale_mul(mdl_acc[i], {1'b0, r.timestep}, FRAC_BITS);
                    vt = scale_mul(mdl_vel[i], {1'b0, r.timestep}, FRAC_BITS);
                    h = scale_mul(at, {1'b0, r.timestep}, FRAC_BITS + 1);
                    mdl_pos[i] = sat128(sx(mdl_pos[i]) + sx(vt) + sx(h));
                    mdl_vel[i] = sat128(sx(mdl_vel[i]) + sx(at));
                    d[i] = mdl_pos[i];
                end
            end
            REQ_LOAD: begin
                mdl_pos[0] = r.in_x; mdl_pos[1] = r.in_y; mdl_pos[2] = r.in_z;
                mdl_vel[0] = r.in_vx; mdl_vel[1] = r.in_vy; mdl_vel[2] = r.in_vz;
                for (int i = 0; i < 3; i++) begin
                    mdl_acc[i] = 0;
                    d[i] = mdl_pos[i];
                end
            end
            default: ;
        endcase
        o.out_x = d[0]; o.out_y = d[1]; o.out_z = d[2];
        o.out_vx = mdl_vel[0]; o.out_vy = mdl_vel[1]; o.out_vz = mdl_vel[2];
        o.acc_x = mdl_acc[0]; o.acc_y = mdl_acc[1]; o.acc_z = mdl_acc[2];
        // advance reports the applied acceleration, then clears it
        if (r.req_type == REQ_ADVANCE) begin
            for (int i = 0; i < 3; i++) mdl_acc[i] = 0;
        end
        return o;
    endfunction

    // receiver: stall pattern and result compare
    logic [7:0] stall_pat;
    always @(posedge aclk) begin
        rsp_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            stall_pat <= {stall_pat[6:0], stall_pat[7] ^ stall_pat[5] ^ stall_pat[4]
                          ^ stall_pat[3]};
            m_ready <= (cycles % 4096 < 1024) ? 1'b1 : (stall_pat[1:0] != 2'b00);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected result %p", $time, m_data);
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    if (e !== m_data) begin
                        $display("%0t mismatch expected %p actual %p", $time, e, m_data);
                        errors++;
                    end
                end
            end
        end
    end

    initial stall_pat = 8'h5a;

    // holds the beat until it is taken; valid stays high for the caller to drop
    task automatic send(input req_t r, input logic typed, input rsp_t rs);
        rsp_t e;
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        e = body_step(r);
        if (typed) e = rs;
        expected_q.insert(expected_q.size(), e);
    endtask

    task automatic reg_write(input int idx, input logic [62:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= (idx == 0) ? ADDR_OWN_MASS : ADDR_G_SCALE; pwdata <= {1'b0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx != 0) mdl_g = v;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (700) @(posedge aclk);
    endtask

    function automatic logic [63:0] rnd64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = S64_MAX;
            1: v = S64_MIN;
            2: v = {{32{v[63]}}, v[31:0]};
            3: v = {{40{v[63]}}, v[23:0]};
            default: v = {{20{v[63]}}, v[43:0]};
        endcase
        return v;
    endfunction

    function automatic logic [62:0] rnd_pos63();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: v = 64'h7FFF_FFFF_FFFF_FFFF;
            1: v = 0;
            2: v = {32'd0, v[31:0]};
            default: v = {26'd0, v[37:0]};
        endcase
        return v[62:0];
    endfunction

    function automatic req_t rnd_req();
        req_t r;
        int k;
        k = $urandom_range(0, 19);
        r.req_type = (k < 12) ? REQ_INTERACT : (k < 16) ? REQ_ADVANCE :
                     (k < 19) ? REQ_LOAD : REQ_NONE;
        r.in_x = rnd64(); r.in_y = rnd64(); r.in_z = rnd64();
        r.in_vx = rnd64(); r.in_vy = rnd64(); r.in_vz = rnd64();
        r.other_mass = rnd_pos63();
        r.timestep = rnd_pos63();
        // sometimes aim the other body at the current position
        if ($urandom_range(0, 40) == 0) begin
            r.req_type = REQ_INTERACT;
            r.in_x = mdl_pos[0]; r.in_y = mdl_pos[1]; r.in_z = mdl_pos[2];
        end
        return r;
    endfunction

    typedef struct {
        req_t  rq;
        logic  typed;
        rsp_t  rs;
    } vec_t;

    localparam logic [63:0] Q1 = 64'h1_0000_0000;

    function automatic req_t mk_req(input req_code_t c, input logic [63:0] x,
                                    input logic [63:0] y, input logic [63:0] z,
                                    input logic [63:0] v, input logic [62:0] m,
                                    input logic [62:0] t);
        req_t r;
        r.req_type = c; r.in_x = x; r.in_y = y; r.in_z = z;
        r.in_vx = v; r.in_vy = 64'd0 - v; r.in_vz = v; r.other_mass = m; r.timestep = t;
        return r;
    endfunction

    vec_t vecs [$];

    initial begin
        vec_t v;
        rsp_t zero_rsp;
        req_t r;
        int burst;
        int gap;
        aresetn = 1'b0;
        s_valid = 1'b0; s_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mdl_g = ONE_Q;
        for (int i = 0; i < 3; i++) begin
            mdl_pos[i] = 0; mdl_vel[i] = 0; mdl_acc[i] = 0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        zero_rsp = '0;
        // coincident at reset: error, all held at zero
        v.rq = mk_req(REQ_INTERACT, 0, 0, 0, 0, ONE_Q, 0); v.typed = 1; v.rs = zero_rsp;
        v.rs.status = 1'b1; vecs.insert(vecs.size(), v);
        v.rq = mk_req(REQ_ADVANCE, 0, 0, 0, 0, 0, ONE_Q); v.typed = 1; v.rs = zero_rsp;
        vecs.insert(vecs.size(), v);
        v.rq = mk_req(REQ_NONE, 5, 6, 7, 8, 9, 10); v.typed = 1; v.rs = zero_rsp;
        vecs.insert(vecs.size(), v);
        v.rq = mk_req(REQ_LOAD, S64_MAX, S64_MIN, Q1, S64_MAX, 0, 0); v.typed = 1;
        v.rs = zero_rsp; v.rs.out_x = S64_MAX; v.rs.out_y = S64_MIN; v.rs.out_z = Q1;
        v.rs.out_vx = S64_MAX; v.rs.out_vy = 64'd0 - S64_MAX; v.rs.out_vz = S64_MAX;
        vecs.insert(vecs.size(), v);
        v.typed = 0;
        v.rq = mk_req(REQ_INTERACT, S64_MIN, S64_MAX, 0, 0, 63'h7FFF_FFFF_FFFF_FFFF, 0);
        vecs.insert(vecs.size(), v);
        v.rq = mk_req(REQ_ADVANCE, 0, 0, 0, 0, 0, 63'h7FFF_FFFF_FFFF_FFFF);
        vecs.insert(vecs.size(), v);
        v.rq = mk_req(REQ_LOAD, 0, 0, 0, Q1, 0, 0); vecs.insert(vecs.size(), v);
        v.rq = mk_req(REQ_INTERACT, Q1, 0, 0, 0, ONE_Q, 0); vecs.insert(vecs.size(), v);
        v.rq = mk_req(REQ_INTERACT, 0, 64'd0 - 2 * Q1, 3 * Q1, 0, ONE_Q, 0);
        vecs.insert(vecs.size(), v);
        v.rq = mk_req(REQ_INTERACT, 1, 0, 0, 0, 63'h7FFF_FFFF_FFFF_FFFF, 0);
        vecs.insert(vecs.size(), v);
        v.rq = mk_req(REQ_ADVANCE, 0, 0, 0, 0, 0, ONE_Q); vecs.insert(vecs.size(), v);
        v.rq = mk_req(REQ_ADVANCE, 0, 0, 0, 0, 0, 0); vecs.insert(vecs.size(), v);
        v.rq = mk_req(REQ_INTERACT, 0, 0, 0, 0, 0, 0); vecs.insert(vecs.size(), v);
        v.rq = mk_req(REQ_LOAD, S64_MIN, S64_MIN, S64_MIN, S64_MIN, 0, 0);
        vecs.insert(vecs.size(), v);
        v.rq = mk_req(REQ_INTERACT, S64_MAX, S64_MAX, S64_MAX, 0, ONE_Q, 0);
        vecs.insert(vecs.size(), v);
        v.rq = mk_req(REQ_ADVANCE, 0, 0, 0, 0, 0, 63'h7FFF_FFFF_FFFF_FFFF);
        vecs.insert(vecs.size(), v);

        foreach (vecs[i]) begin
            send(vecs[i].rq, vecs[i].typed, vecs[i].rs);
        end
        s_valid <= 1'b0;
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin reg_write(0, 63'h7FFF_FFFF_FFFF_FFFF); reg_write(1, 0); end
                1: begin reg_write(0, 0); reg_write(1, 63'h7FFF_FFFF_FFFF_FFFF); end
                2: begin reg_write(0, ONE_Q); reg_write(1, ONE_Q); end
                default: begin reg_write(0, rnd_pos63()); reg_write(1, rnd_pos63()); end
            endcase
            for (int n = 0; n < N_RANDOM / 5; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < N_RANDOM / 5; b++) begin
                    r = rnd_req();
                    send(r, 1'b0, zero_rsp);
                    if (r.req_type != REQ_NONE) n++;
                end
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            if (gap == 0) s_valid <= 1'b0;
            drain();
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
